// ===== rtl/core/smb_pkg.sv =====
// shared types, codes and helpers for the sprite motion bounds core
package smb_pkg;

    localparam int COORD_W = 12;
    localparam int SPAN_W  = 11;
    localparam int WIDE_W  = 14;

    localparam logic signed [COORD_W-1:0] COORD_MIN = -12'sd2048;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 12'sd2047;

    // screen defaults: 640 x 480, inclusive right and bottom edges
    localparam logic signed [COORD_W-1:0] RST_BOUND_RIGHT  = 12'sd639;
    localparam logic signed [COORD_W-1:0] RST_BOUND_BOTTOM = 12'sd479;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_DELAY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SHOT     = 3'd7;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_MOVE = 2'd1,
        REQ_VEL  = 2'd2,
        REQ_SPAN = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        EDGE_STOP   = 2'd0,
        EDGE_WRAP   = 2'd1,
        EDGE_BOUNCE = 2'd2,
        EDGE_DIE    = 2'd3
    } t_edge;

    // per-axis result handed from the axis unit to the top level
    typedef struct packed {
        logic signed [COORD_W-1:0] pos;
        logic signed [COORD_W-1:0] vel;
        logic                      stop_hit;
        logic                      outside;
    } t_axis_res;

    // sprite state
    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] vel_x;
        logic signed [COORD_W-1:0] vel_y;
        logic [SPAN_W-1:0]         span_x;
        logic [SPAN_W-1:0]         span_y;
        logic [7:0]                frame;
        logic signed [8:0]         countdown;
        logic                      dying;
    } t_state;

    function automatic logic signed [WIDE_W-1:0] ext_wide(input logic signed [COORD_W-1:0] v);
        return {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    // saturate a wide value to the coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v < ext_wide(COORD_MIN)) begin
            r = COORD_MIN;
        end else if (v > ext_wide(COORD_MAX)) begin
            r = COORD_MAX;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // negate with saturation, most negative maps to most positive
    function automatic logic signed [COORD_W-1:0] neg_coord(input logic signed [COORD_W-1:0] v);
        return sat_coord(-ext_wide(v));
    endfunction

endpackage

// ===== rtl/core/smb_axis.sv =====
// one axis of the motion step: saturating advance and edge action
module smb_axis (
    input  logic signed [smb_pkg::COORD_W-1:0] i_pos,
    input  logic signed [smb_pkg::COORD_W-1:0] i_vel,
    input  logic signed [smb_pkg::COORD_W-1:0] i_low,
    input  logic signed [smb_pkg::COORD_W-1:0] i_high,
    input  logic [smb_pkg::SPAN_W-1:0]         i_span,
    input  smb_pkg::t_edge                     i_mode,
    output smb_pkg::t_axis_res                 o_res
);
    import smb_pkg::*;

    logic signed [COORD_W-1:0] step_pos;
    logic signed [WIDE_W-1:0]  sum_w;
    logic signed [WIDE_W-1:0]  low_w;
    logic signed [WIDE_W-1:0]  high_w;
    logic signed [WIDE_W-1:0]  span_w;
    logic signed [WIDE_W-1:0]  far_w;
    logic signed [WIDE_W-1:0]  lim_w;
    logic signed [WIDE_W-1:0]  clip_w;

    // advance and full-precision edge terms
    assign step_pos = sat_coord(ext_wide(i_pos) + ext_wide(i_vel));
    assign sum_w    = ext_wide(step_pos);
    assign low_w    = ext_wide(i_low);
    assign high_w   = ext_wide(i_high);
    assign span_w   = $signed({{(WIDE_W-SPAN_W){1'b0}}, i_span});
    assign far_w    = sum_w + span_w;
    assign lim_w    = high_w - span_w;
    assign clip_w   = (sum_w < lim_w) ? sum_w : lim_w;

    // edge action
    always_comb begin
        o_res.pos      = step_pos;
        o_res.vel      = i_vel;
        o_res.stop_hit = 1'b0;
        o_res.outside  = (far_w < low_w) || (sum_w > high_w);
        unique case (i_mode)
            EDGE_STOP: begin
                if (sum_w < low_w || sum_w > lim_w) begin
                    o_res.pos      = sat_coord((clip_w > low_w) ? clip_w : low_w);
                    o_res.stop_hit = 1'b1;
                end
            end
            EDGE_WRAP: begin
                if (far_w < low_w) begin
                    o_res.pos = i_high;
                end else if (sum_w > high_w) begin
                    o_res.pos = sat_coord(low_w - span_w);
                end
            end
            EDGE_BOUNCE: begin
                if (sum_w < low_w) begin
                    o_res.pos = i_low;
                    o_res.vel = neg_coord(i_vel);
                end else if (far_w > high_w) begin
                    o_res.pos = sat_coord(lim_w);
                    o_res.vel = neg_coord(i_vel);
                end
            end
            EDGE_DIE: begin
                o_res.pos = step_pos;
            end
            default: begin
                o_res.pos = step_pos;
            end
        endcase
    end

endmodule

// ===== rtl/core/sprite_motion_bounds_update_core.sv =====
// sprite motion engine top level: config registers, item register, state and result register
//
//   channel   direction  handshake                  payload
//   in        in         i_in_valid / o_in_stall    i_req_type i_value_x i_value_y
//   out       out        o_out_valid / i_out_stall  o_kill o_pos_x o_pos_y o_vel_x o_vel_y
//                                                   o_frame_index
//   cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index i_cfg_data
//
// an item passes through the item register and then the result register; one item per cycle
// is sustained while the output is not stalled, set by the single next-state step that updates
// the sprite state from the item register. i_rst_n is synchronous and active low; it
// clears state, config and both valid flags. a stalled result holds the result register,
// and the input stalls only when the item register is full behind it.
module sprite_motion_bounds_update_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_req_type,
    input  logic signed [smb_pkg::COORD_W-1:0] i_value_x,
    input  logic signed [smb_pkg::COORD_W-1:0] i_value_y,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_kill,
    output logic signed [smb_pkg::COORD_W-1:0] o_pos_x,
    output logic signed [smb_pkg::COORD_W-1:0] o_pos_y,
    output logic signed [smb_pkg::COORD_W-1:0] o_vel_x,
    output logic signed [smb_pkg::COORD_W-1:0] o_vel_y,
    output logic [7:0]                         o_frame_index,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [smb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [smb_pkg::COORD_W-1:0]        i_cfg_data
);
    import smb_pkg::*;

    // configuration registers
    logic signed [COORD_W-1:0] r_bound_left;
    logic signed [COORD_W-1:0] r_bound_top;
    logic signed [COORD_W-1:0] r_bound_right;
    logic signed [COORD_W-1:0] r_bound_bottom;
    t_edge                     r_edge_mode;
    logic signed [8:0]         r_frame_delay;
    logic [7:0]                r_frame_total;
    logic                      r_one_shot;

    // item register
    logic                      r_in_vld;
    t_req                      r_in_req;
    logic signed [COORD_W-1:0] r_in_x;
    logic signed [COORD_W-1:0] r_in_y;

    // sprite state and result register
    t_state                    r_state;
    t_state                    n_state;
    logic                      n_kill;
    logic                      r_out_vld;
    logic                      r_out_kill;
    t_state                    r_out_state;

    logic                      advance;
    logic                      accept_in;
    t_axis_res                 res_x;
    t_axis_res                 res_y;

    logic signed [9:0]         dec_count;
    logic                      reload;
    logic [8:0]                next_frame;
    logic                      frame_wrap;
    logic [7:0]                adv_frame;

    // handshake
    assign advance     = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !advance;
    assign accept_in   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_left   <= '0;
            r_bound_top    <= '0;
            r_bound_right  <= RST_BOUND_RIGHT;
            r_bound_bottom <= RST_BOUND_BOTTOM;
            r_edge_mode    <= EDGE_STOP;
            r_frame_delay  <= '0;
            r_frame_total  <= 8'd1;
            r_one_shot     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BOUND_LEFT:   r_bound_left   <= $signed(i_cfg_data);
                CFG_BOUND_TOP:    r_bound_top    <= $signed(i_cfg_data);
                CFG_BOUND_RIGHT:  r_bound_right  <= $signed(i_cfg_data);
                CFG_BOUND_BOTTOM: r_bound_bottom <= $signed(i_cfg_data);
                CFG_EDGE_MODE:    r_edge_mode    <= t_edge'(i_cfg_data[1:0]);
                CFG_FRAME_DELAY:  r_frame_delay  <= $signed(i_cfg_data[8:0]);
                CFG_FRAME_TOTAL:  r_frame_total  <= i_cfg_data[7:0];
                CFG_ONE_SHOT:     r_one_shot     <= i_cfg_data[0];
                default:          r_one_shot     <= r_one_shot;
            endcase
        end
    end

    // item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept_in) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_req <= t_req'(i_req_type);
            r_in_x   <= i_value_x;
            r_in_y   <= i_value_y;
        end
    end

    // per-axis motion units
    smb_axis u_axis_x (
        .i_pos  (r_state.pos_x),
        .i_vel  (r_state.vel_x),
        .i_low  (r_bound_left),
        .i_high (r_bound_right),
        .i_span (r_state.span_x),
        .i_mode (r_edge_mode),
        .o_res  (res_x)
    );

    smb_axis u_axis_y (
        .i_pos  (r_state.pos_y),
        .i_vel  (r_state.vel_y),
        .i_low  (r_bound_top),
        .i_high (r_bound_bottom),
        .i_span (r_state.span_y),
        .i_mode (r_edge_mode),
        .o_res  (res_y)
    );

    // animation counter terms
    assign dec_count  = {r_state.countdown[8], r_state.countdown} - 10'sd1;
    assign reload     = dec_count[9] || (dec_count == 10'sd0);
    assign next_frame = {1'b0, r_state.frame} + 9'd1;
    assign frame_wrap = next_frame >= {1'b0, r_frame_total};
    assign adv_frame  = !frame_wrap ? next_frame[7:0] :
                        !r_one_shot ? 8'd0 :
                        next_frame[8] ? 8'hFF : next_frame[7:0];

    // next sprite state for the item in the item register
    always_comb begin
        n_state = r_state;
        n_kill  = 1'b0;
        unique case (r_in_req)
            REQ_MOVE: begin
                n_state.pos_x = r_in_x;
                n_state.pos_y = r_in_y;
            end
            REQ_VEL: begin
                n_state.vel_x = r_in_x;
                n_state.vel_y = r_in_y;
            end
            REQ_SPAN: begin
                n_state.span_x = r_in_x[COORD_W-1] ? '0 : r_in_x[SPAN_W-1:0];
                n_state.span_y = r_in_y[COORD_W-1] ? '0 : r_in_y[SPAN_W-1:0];
            end
            REQ_TICK: begin
                if (r_state.dying) begin
                    n_kill = 1'b1;
                end else begin
                    // animation
                    if (!r_frame_delay[8]) begin
                        if (!reload) begin
                            n_state.countdown = dec_count[8:0];
                        end else begin
                            n_state.countdown = r_frame_delay;
                            n_state.frame     = adv_frame;
                            n_state.dying     = frame_wrap && r_one_shot;
                        end
                    end
                    // motion
                    if (r_edge_mode == EDGE_DIE && (res_x.outside || res_y.outside)) begin
                        n_kill = 1'b1;
                    end else begin
                        n_state.pos_x = res_x.pos;
                        n_state.pos_y = res_y.pos;
                        if (r_edge_mode == EDGE_STOP && (res_x.stop_hit || res_y.stop_hit)) begin
                            n_state.vel_x = '0;
                            n_state.vel_y = '0;
                        end else begin
                            n_state.vel_x = res_x.vel;
                            n_state.vel_y = res_y.vel;
                        end
                    end
                end
            end
            default: begin
                n_kill = 1'b0;
            end
        endcase
    end

    // sprite state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_kill  <= n_kill;
            r_out_state <= n_state;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_kill        = r_out_kill;
    assign o_pos_x       = r_out_state.pos_x;
    assign o_pos_y       = r_out_state.pos_y;
    assign o_vel_x       = r_out_state.vel_x;
    assign o_vel_y       = r_out_state.vel_y;
    assign o_frame_index = r_out_state.frame;

endmodule

// ===== rtl/core/smb_chk.sv =====
// port-level checks for the sprite motion core and their bind
module smb_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_kill,
    input logic signed [smb_pkg::COORD_W-1:0] o_pos_x,
    input logic signed [smb_pkg::COORD_W-1:0] o_pos_y,
    input logic [7:0]                         o_frame_index
);

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input stalls only when a result is waiting and held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // a held result transaction stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("held result dropped");

    // a held result transaction keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_kill) && $stable(o_pos_x) && $stable(o_pos_y) &&
             $stable(o_frame_index)))
        else $error("held result payload changed");

endmodule

bind sprite_motion_bounds_update_core smb_chk u_smb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kill        (o_kill),
    .o_pos_x       (o_pos_x),
    .o_pos_y       (o_pos_y),
    .o_frame_index (o_frame_index)
);
